// ----- hdl/adri_pkg.sv -----
// ----------------------------------------------------------------------------
// adri_pkg
// Shared widths, codes and reset values for the one-axis accelerometer
// dead-reckoning integrator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package adri_pkg;

  localparam int RAW_W      = 16;
  localparam int TIME_W     = 32;
  localparam int VEL_W      = 48;
  localparam int PEAK_W     = 47;
  localparam int DZ_W       = 15;
  localparam int GAIN_W     = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;
  localparam int CAL_CNT_W  = 7;
  localparam int CAL_SUM_W  = 24;
  localparam int OFFSET_W   = 17;
  localparam int ACCEL_W    = 18;
  localparam int PROD_W     = 56;
  localparam int ACC_W      = 104;
  localparam int DV_SHIFT   = 24;
  localparam int DD_SHIFT   = 40;

  typedef enum logic [1:0] {
    ST_CAL    = 2'd0,
    ST_STILL  = 2'd1,
    ST_MOVING = 2'd2,
    ST_DONE   = 2'd3
  } status_t;

  localparam logic [CFG_IDX_W-1:0] REG_DEADZONE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL_GAIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_RECIP = 2'd2;

  localparam logic [DZ_W-1:0]   DEADZONE_RST = 15'd1638;
  localparam logic [GAIN_W-1:0] GAIN_RST     = 24'd168531;
  localparam logic [GAIN_W-1:0] RECIP_RST    = 24'd1099512;

  localparam logic [VEL_W-1:0]  VEL_MAX  = {1'b0, {(VEL_W-1){1'b1}}};
  localparam logic [VEL_W-1:0]  VEL_MIN  = {1'b1, {(VEL_W-1){1'b0}}};
  localparam logic [PEAK_W-1:0] PEAK_MAX = {PEAK_W{1'b1}};

endpackage

// ----- hdl/adri_in_if.sv -----
// ----------------------------------------------------------------------------
// adri_in_if
// Sample channel: raw acceleration, read status and timestamp.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface adri_in_if import adri_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [RAW_W-1:0]  raw_accel;
  logic                     sample_ok;
  logic [TIME_W-1:0]        time_us;

  modport source (output valid, raw_accel, sample_ok, time_us, input ready);
  modport sink   (input valid, raw_accel, sample_ok, time_us, output ready);
endinterface

// ----- hdl/adri_out_if.sv -----
// ----------------------------------------------------------------------------
// adri_out_if
// Result channel: status, velocity, distance and peak speed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface adri_out_if import adri_pkg::*; ();
  logic                     valid;
  logic                     ready;
  status_t                  status;
  logic signed [VEL_W-1:0]  velocity;
  logic signed [VEL_W-1:0]  distance;
  logic [PEAK_W-1:0]        peak_speed;

  modport source (output valid, status, velocity, distance, peak_speed, input ready);
  modport sink   (input valid, status, velocity, distance, peak_speed, output ready);
endinterface

// ----- hdl/accel_dead_reckon_integrator_core.sv -----
// ----------------------------------------------------------------------------
// accel_dead_reckon_integrator_core
// One-axis accelerometer zero calibration, deadzone and double integration.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// The first CAL_SAMPLES transactions calibrate the zero offset and return
// status 0; every later transaction returns one result with status still,
// moving or move complete. Work runs through a single 32x24 multiplier and
// one 104-bit accumulator under a small sequencer, one transaction at a time.
// The last calibration transaction also forms the rounded offset (one pass of
// the multiplier by the reciprocal of the sample count); a still or
// move-complete transaction goes from the deadzone check straight to output;
// a moving transaction makes two passes of seven multiplier steps (velocity
// step, then distance step). The result sits in an output register,
// so the next transaction is accepted while it waits to be taken.

module accel_dead_reckon_integrator_core import adri_pkg::*; #(
  parameter int CAL_SAMPLES = 100
) (
  input  logic                  clk,
  input  logic                  rst_n,
  adri_in_if.sink               in_ch,
  adri_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam logic [CAL_CNT_W-1:0] CAL_N     = CAL_CNT_W'(CAL_SAMPLES);
  localparam logic [CAL_SUM_W-1:0] CAL_HALF  = CAL_SUM_W'(CAL_SAMPLES / 2);
  localparam int                   CAL_SHIFT = 30;
  localparam logic [31:0]          CAL_RECIP =
    32'((2**CAL_SHIFT + CAL_SAMPLES - 1) / CAL_SAMPLES);

  typedef enum logic [3:0] {
    S_IDLE, S_DPREP, S_DIV, S_DFIN, S_CHK, S_MUL,
    S_SCALE, S_VADD, S_VMAG, S_DADD, S_OUT
  } state_t;

  function automatic logic [VEL_W-1:0] sat_add(input logic [VEL_W-1:0] x,
                                               input logic [VEL_W-1:0] y);
    logic [VEL_W:0] s;
    s = {x[VEL_W-1], x} + {y[VEL_W-1], y};
    if (s[VEL_W] != s[VEL_W-1]) begin
      sat_add = s[VEL_W] ? VEL_MIN : VEL_MAX;
    end else begin
      sat_add = s[VEL_W-1:0];
    end
  endfunction

  // control state
  state_t                 state_r, state_nxt;
  logic [CAL_CNT_W-1:0]   cal_count_r, cal_count_nxt;
  logic [CAL_SUM_W-1:0]   cal_sum_r, cal_sum_nxt;
  logic [OFFSET_W-1:0]    offset_r, offset_nxt;
  logic [TIME_W-1:0]      prev_time_r, prev_time_nxt;
  logic [ACCEL_W-1:0]     prev_accel_r, prev_accel_nxt;
  logic [VEL_W-1:0]       vel_r, vel_nxt;
  logic [VEL_W-1:0]       dist_r, dist_nxt;
  logic [PEAK_W-1:0]      peak_r, peak_nxt;
  logic [DZ_W-1:0]        deadzone_r, deadzone_nxt;
  logic [GAIN_W-1:0]      gain_r, gain_nxt;
  logic [GAIN_W-1:0]      recip_r, recip_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [2:0]             mul_cnt_r, mul_cnt_nxt;
  logic                   is_dd_r, is_dd_nxt;
  logic                   neg_r, neg_nxt;

  // datapath
  logic [TIME_W-1:0]      dt_r, dt_nxt;
  logic [CAL_SUM_W-1:0]   num_r, num_nxt;
  logic [VEL_W-1:0]       v_r, v_nxt;
  logic [PROD_W-1:0]      prod_r, prod_nxt;
  logic [PROD_W-1:0]      w_r, w_nxt;
  logic [ACC_W-1:0]       acc_r, acc_nxt;
  logic [VEL_W-1:0]       sc_r, sc_nxt;
  status_t                status_r, status_nxt;
  status_t                out_status_r, out_status_nxt;
  logic [VEL_W-1:0]       out_vel_r, out_vel_nxt;
  logic [VEL_W-1:0]       out_dist_r, out_dist_nxt;
  logic [PEAK_W-1:0]      out_peak_r, out_peak_nxt;

  // shared multiplier
  logic [1:0]             mul_idx, acc_idx;
  logic [31:0]            mul_a;
  logic [GAIN_W-1:0]      mul_b;
  logic [PROD_W-1:0]      mul_out;
  logic [6:0]             pp_sh;

  // temporaries
  logic [ACCEL_W-1:0]     amag;
  logic                   sc_ovf, sc_rem;
  logic [PEAK_W-1:0]      sc_q;
  logic [VEL_W-1:0]       sc_mag;
  logic [VEL_W-1:0]       vmag;
  logic [PEAK_W-1:0]      vabs;

  assign mul_idx = 2'(mul_cnt_r - 3'd2);
  assign acc_idx = 2'(mul_cnt_r - 3'd3);
  assign mul_a   = (state_r == S_DIV) ? CAL_RECIP :
                   (mul_cnt_r == 3'd0) ? dt_r :
                   (mul_idx[1] ? {8'd0, w_r[PROD_W-1:32]} : w_r[31:0]);
  assign mul_b   = (state_r == S_DIV) ? num_r :
                   (mul_cnt_r == 3'd0) ? (is_dd_r ? recip_r : gain_r) :
                   (mul_idx[0] ? v_r[VEL_W-1:24] : v_r[23:0]);
  assign mul_out = PROD_W'(mul_a) * PROD_W'(mul_b);
  assign pp_sh   = (acc_idx[1] ? 7'd32 : 7'd0) + (acc_idx[0] ? 7'd24 : 7'd0);

  assign in_ch.ready       = (state_r == S_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.velocity   = out_vel_r;
  assign out_ch.distance   = out_dist_r;
  assign out_ch.peak_speed = out_peak_r;

  always_comb begin
    state_nxt      = state_r;
    cal_count_nxt  = cal_count_r;
    cal_sum_nxt    = cal_sum_r;
    offset_nxt     = offset_r;
    prev_time_nxt  = prev_time_r;
    prev_accel_nxt = prev_accel_r;
    vel_nxt        = vel_r;
    dist_nxt       = dist_r;
    peak_nxt       = peak_r;
    deadzone_nxt   = deadzone_r;
    gain_nxt       = gain_r;
    recip_nxt      = recip_r;
    out_valid_nxt  = out_valid_r;
    mul_cnt_nxt    = mul_cnt_r;
    is_dd_nxt      = is_dd_r;
    neg_nxt        = neg_r;
    dt_nxt         = dt_r;
    num_nxt        = num_r;
    v_nxt          = v_r;
    prod_nxt       = prod_r;
    w_nxt          = w_r;
    acc_nxt        = acc_r;
    sc_nxt         = sc_r;
    status_nxt     = status_r;
    out_status_nxt = out_status_r;
    out_vel_nxt    = out_vel_r;
    out_dist_nxt   = out_dist_r;
    out_peak_nxt   = out_peak_r;

    amag      = prev_accel_r[ACCEL_W-1] ? (ACCEL_W'(0) - prev_accel_r) : prev_accel_r;
    if (is_dd_r) begin
      sc_ovf = |acc_r[ACC_W-1:DD_SHIFT+PEAK_W];
      sc_q   = acc_r[DD_SHIFT+PEAK_W-1:DD_SHIFT];
      sc_rem = |acc_r[DD_SHIFT-1:0];
    end else begin
      sc_ovf = |acc_r[ACC_W-1:DV_SHIFT+PEAK_W];
      sc_q   = acc_r[DV_SHIFT+PEAK_W-1:DV_SHIFT];
      sc_rem = |acc_r[DV_SHIFT-1:0];
    end
    sc_mag = {1'b0, sc_q} + VEL_W'(sc_rem);
    vmag   = vel_r[VEL_W-1] ? (VEL_W'(0) - vel_r) : vel_r;
    vabs   = vmag[VEL_W-1] ? PEAK_MAX : vmag[PEAK_W-1:0];

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_we) begin
      case (cfg_index)
        REG_DEADZONE:   deadzone_nxt = cfg_wdata[DZ_W-1:0];
        REG_ACCEL_GAIN: gain_nxt     = cfg_wdata[GAIN_W-1:0];
        REG_TIME_RECIP: recip_nxt    = cfg_wdata[GAIN_W-1:0];
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          prev_time_nxt = in_ch.time_us;
          if (cal_count_r < CAL_N) begin
            if (in_ch.sample_ok) begin
              cal_sum_nxt = cal_sum_r + {{(CAL_SUM_W-RAW_W){in_ch.raw_accel[RAW_W-1]}},
                                         in_ch.raw_accel};
            end
            cal_count_nxt = cal_count_r + 1'b1;
            status_nxt    = ST_CAL;
            state_nxt     = (cal_count_r == CAL_N - 1'b1) ? S_DPREP : S_OUT;
          end else begin
            dt_nxt = in_ch.time_us - prev_time_r;
            if (in_ch.sample_ok) begin
              prev_accel_nxt = {{(ACCEL_W-RAW_W){in_ch.raw_accel[RAW_W-1]}},
                                in_ch.raw_accel}
                             - {offset_r[OFFSET_W-1], offset_r};
            end
            state_nxt = S_CHK;
          end
        end
      end
      S_DPREP: begin
        num_nxt   = (cal_sum_r[CAL_SUM_W-1] ? (CAL_SUM_W'(0) - cal_sum_r) : cal_sum_r)
                  + CAL_HALF;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        prod_nxt  = mul_out;
        state_nxt = S_DFIN;
      end
      S_DFIN: begin
        offset_nxt = cal_sum_r[CAL_SUM_W-1]
                   ? (OFFSET_W'(0) - prod_r[CAL_SHIFT+OFFSET_W-1:CAL_SHIFT])
                   : prod_r[CAL_SHIFT+OFFSET_W-1:CAL_SHIFT];
        state_nxt  = S_OUT;
      end
      S_CHK: begin
        if (amag[OFFSET_W-1:0] > {2'd0, deadzone_r}) begin
          v_nxt       = VEL_W'(amag[OFFSET_W-1:0]);
          neg_nxt     = prev_accel_r[ACCEL_W-1];
          is_dd_nxt   = 1'b0;
          mul_cnt_nxt = '0;
          state_nxt   = S_MUL;
        end else begin
          status_nxt = (vel_r != '0) ? ST_DONE : ST_STILL;
          state_nxt  = S_OUT;
        end
      end
      S_MUL: begin
        prod_nxt = mul_out;
        case (mul_cnt_r)
          3'd0: acc_nxt = '0;
          3'd1: w_nxt   = prod_r;
          3'd2: ;
          default: acc_nxt = acc_r + (ACC_W'(prod_r) << pp_sh);
        endcase
        mul_cnt_nxt = mul_cnt_r + 1'b1;
        if (mul_cnt_r == 3'd6) begin
          state_nxt = S_SCALE;
        end
      end
      S_SCALE: begin
        if (neg_r) begin
          sc_nxt = sc_ovf ? VEL_MIN : (VEL_W'(0) - sc_mag);
        end else begin
          sc_nxt = sc_ovf ? VEL_MAX : {1'b0, sc_q};
        end
        state_nxt = is_dd_r ? S_DADD : S_VADD;
      end
      S_VADD: begin
        vel_nxt   = sat_add(vel_r, sc_r);
        state_nxt = S_VMAG;
      end
      S_VMAG: begin
        v_nxt       = vmag;
        neg_nxt     = vel_r[VEL_W-1];
        is_dd_nxt   = 1'b1;
        mul_cnt_nxt = '0;
        if (vabs > peak_r) begin
          peak_nxt = vabs;
        end
        state_nxt = S_MUL;
      end
      S_DADD: begin
        dist_nxt   = sat_add(dist_r, sc_r);
        status_nxt = ST_MOVING;
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          case (status_r)
            ST_CAL: begin
              out_vel_nxt  = '0;
              out_dist_nxt = '0;
              out_peak_nxt = '0;
            end
            ST_DONE: begin
              out_vel_nxt  = '0;
              out_dist_nxt = dist_r;
              out_peak_nxt = peak_r;
              vel_nxt      = '0;
              dist_nxt     = '0;
              peak_nxt     = '0;
            end
            default: begin
              out_vel_nxt  = vel_r;
              out_dist_nxt = dist_r;
              out_peak_nxt = peak_r;
            end
          endcase
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cal_count_r  <= '0;
      cal_sum_r    <= '0;
      offset_r     <= '0;
      prev_time_r  <= '0;
      prev_accel_r <= '0;
      vel_r        <= '0;
      dist_r       <= '0;
      peak_r       <= '0;
      deadzone_r   <= DEADZONE_RST;
      gain_r       <= GAIN_RST;
      recip_r      <= RECIP_RST;
      out_valid_r  <= 1'b0;
      mul_cnt_r    <= '0;
      is_dd_r      <= 1'b0;
      neg_r        <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cal_count_r  <= cal_count_nxt;
      cal_sum_r    <= cal_sum_nxt;
      offset_r     <= offset_nxt;
      prev_time_r  <= prev_time_nxt;
      prev_accel_r <= prev_accel_nxt;
      vel_r        <= vel_nxt;
      dist_r       <= dist_nxt;
      peak_r       <= peak_nxt;
      deadzone_r   <= deadzone_nxt;
      gain_r       <= gain_nxt;
      recip_r      <= recip_nxt;
      out_valid_r  <= out_valid_nxt;
      mul_cnt_r    <= mul_cnt_nxt;
      is_dd_r      <= is_dd_nxt;
      neg_r        <= neg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dt_r         <= dt_nxt;
    num_r        <= num_nxt;
    v_r          <= v_nxt;
    prod_r       <= prod_nxt;
    w_r          <= w_nxt;
    acc_r        <= acc_nxt;
    sc_r         <= sc_nxt;
    status_r     <= status_nxt;
    out_status_r <= out_status_nxt;
    out_vel_r    <= out_vel_nxt;
    out_dist_r   <= out_dist_nxt;
    out_peak_r   <= out_peak_nxt;
  end

  a_cal_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cal_count_r <= CAL_N)
    else $error("calibration count past limit");

  a_done_zero_vel: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status == ST_DONE) |-> (out_ch.velocity == '0))
    else $error("move complete transaction with nonzero velocity");

  a_cal_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status == ST_CAL) |->
    (out_ch.distance == '0 && out_ch.peak_speed == '0))
    else $error("calibration transaction with nonzero fields");

  a_mul_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL) |-> (mul_cnt_r <= 3'd6))
    else $error("multiplier step counter out of range");

  a_cal_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && cal_count_r < CAL_N - 1'b1) |=> (state_r == S_OUT))
    else $error("calibration transaction did not go straight to output");

endmodule

// ----- test/accel_dead_reckon_integrator_core_tb.sv -----
// ----------------------------------------------------------------------------
// accel_dead_reckon_integrator_core_tb
// Drives calibration, directed corner cases and random motion sequences into
// the integrator under several register settings, predicts every result with
// its own fixed-point integrator and compares each result transaction field by
// field. Both channels idle at random, and the result side stalls at length.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module accel_dead_reckon_integrator_core_tb;
  import adri_pkg::*;

  localparam int CAL_SAMPLES    = 100;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int RESULT_HOLD    = 300;
  localparam int PHASE_ITEMS    = 95;
  localparam longint VEL_TOP    = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint VEL_BOTTOM = -VEL_TOP - 1;
  localparam logic [127:0] MAG_CAP = 128'h1 << 48;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic signed [RAW_W-1:0] raw;
    logic                    ok;
    logic [TIME_W-1:0]       stamp;
  } sample_t;

  typedef struct packed {
    status_t           status;
    logic [VEL_W-1:0]  velocity;
    logic [VEL_W-1:0]  distance;
    logic [PEAK_W-1:0] peak;
  } motion_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  adri_in_if  in_ch ();
  adri_out_if out_ch ();

  accel_dead_reckon_integrator_core #(.CAL_SAMPLES(CAL_SAMPLES)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // integrator state as predicted
  int                cal_seen;
  int                cal_total;
  int                zero_offset;
  int                last_accel;
  logic [TIME_W-1:0] last_stamp = '0;
  longint            vel_now;
  longint            dist_now;
  longint            peak_now;
  logic [DZ_W-1:0]   dz_cfg = DEADZONE_RST;
  logic [GAIN_W-1:0] gain_cfg = GAIN_RST;
  logic [GAIN_W-1:0] recip_cfg = RECIP_RST;

  sample_t           sample_queue[$];
  motion_t           expected_results[$];
  sample_t           next_sample;
  motion_t           want_result;
  logic [TIME_W-1:0] stamp_now = '0;
  int                queued_total;
  int                accepted_total;
  int                results_seen;
  int                mismatches;
  int                idle_cycles;
  int                gap_left;
  int                steady_left;
  int                hold_left;
  int                stall_left;
  int                calm_left;
  int                hold_mark = 150;
  bit                in_taken;
  bit                out_taken;

  function automatic longint clamp48(input longint x);
    if (x > VEL_TOP) return VEL_TOP;
    if (x < VEL_BOTTOM) return VEL_BOTTOM;
    return x;
  endfunction

  // floor(+-mag * m1 * m2 / 2^sh), saturated to the 48-bit range
  function automatic longint scaled_product(input bit neg, input logic [63:0] mag,
                                            input logic [31:0] m1, input logic [31:0] m2,
                                            input int sh);
    logic [127:0] prod;
    logic [127:0] q;
    bit           rem;
    prod = 128'(mag);
    prod = prod * m1;
    prod = prod * m2;
    q = prod >> sh;
    rem = (prod & ((128'h1 << sh) - 128'h1)) != 128'h0;
    if (q > MAG_CAP) q = MAG_CAP;
    if (neg) begin
      if (rem && q < MAG_CAP) q = q + 128'h1;
      return clamp48(-longint'(q[63:0]));
    end
    return clamp48(longint'(q[63:0]));
  endfunction

  function automatic motion_t integrate_sample(input logic signed [RAW_W-1:0] raw,
                                               input logic ok,
                                               input logic [TIME_W-1:0] now);
    motion_t           r;
    logic [TIME_W-1:0] dt;
    int                mag;
    int                q;
    longint            dv;
    longint            dd;
    longint            vmag;
    r = '0;
    if (cal_seen < CAL_SAMPLES) begin
      if (ok) cal_total += int'(raw);
      cal_seen++;
      last_stamp = now;
      if (cal_seen >= CAL_SAMPLES) begin
        mag = cal_total < 0 ? -cal_total : cal_total;
        q = (mag + CAL_SAMPLES / 2) / CAL_SAMPLES;
        zero_offset = cal_total < 0 ? -q : q;
      end
      return r;
    end
    dt = now - last_stamp;
    last_stamp = now;
    if (ok) last_accel = int'(raw) - zero_offset;
    mag = last_accel < 0 ? -last_accel : last_accel;
    if (mag > int'(dz_cfg)) begin
      dv = scaled_product(last_accel < 0, 64'(mag), 32'(gain_cfg), dt, DV_SHIFT);
      vel_now = clamp48(vel_now + dv);
      vmag = vel_now < 0 ? -vel_now : vel_now;
      dd = scaled_product(vel_now < 0, vmag, dt, 32'(recip_cfg), DD_SHIFT);
      dist_now = clamp48(dist_now + dd);
      if (vmag > VEL_TOP) vmag = VEL_TOP;
      if (vmag > peak_now) peak_now = vmag;
      r.status = ST_MOVING;
      r.velocity = vel_now[VEL_W-1:0];
    end else if (vel_now != 0) begin
      r.status = ST_DONE;
    end else begin
      r.status = ST_STILL;
    end
    r.distance = dist_now[VEL_W-1:0];
    r.peak = peak_now[PEAK_W-1:0];
    if (r.status == ST_DONE) begin
      vel_now = 0;
      dist_now = 0;
      peak_now = 0;
    end
    return r;
  endfunction

  function automatic void push_sample(input logic signed [RAW_W-1:0] raw, input bit ok,
                                      input logic [TIME_W-1:0] step);
    stamp_now += step;
    sample_queue.push_back('{raw: raw, ok: ok, stamp: stamp_now});
    queued_total++;
  endfunction

  // raw sample that gives corrected acceleration a
  function automatic logic signed [RAW_W-1:0] raw_for(input int a);
    int v;
    v = zero_offset + a;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return 16'(v);
  endfunction

  function automatic logic [TIME_W-1:0] pick_dt();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(9500, 10500);
    if (r < 90) return $urandom_range(0, 200);
    if (r < 97) return $urandom_range(10000, 2000000);
    return $urandom;
  endfunction

  function automatic int pick_gap();
    int r;
    if (steady_left > 0) begin
      steady_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) steady_left = $urandom_range(20, 80);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 50);
  endfunction

  // still lead-in, a push one way and back, then a return into the deadzone
  function automatic void queue_move();
    int dz;
    int n;
    int i;
    int sgn;
    int span;
    dz = int'(dz_cfg);
    n = $urandom_range(1, 3);
    for (i = 0; i < n; i++) begin
      push_sample(raw_for(($urandom_range(0, 1) ? 1 : -1) * int'($urandom_range(0, dz))),
                  $urandom_range(0, 15) != 0, pick_dt());
    end
    n = $urandom_range(2, 10);
    sgn = $urandom_range(0, 1) ? 1 : -1;
    case ($urandom_range(0, 2))
      0: span = 100;
      1: span = 3000;
      default: span = 30000;
    endcase
    for (i = 0; i < n; i++) begin
      push_sample(raw_for((i < n / 2 ? sgn : -sgn) * (dz + 1 + int'($urandom_range(0, span)))),
                  $urandom_range(0, 7) != 0, pick_dt());
    end
    push_sample(raw_for(sgn * int'($urandom_range(0, dz))), 1'b1, pick_dt());
  endfunction

  function automatic void check_field(input string name, input logic [VEL_W-1:0] want,
                                      input logic [VEL_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      mismatches++;
    end
  endfunction

  task automatic drain();
    while (accepted_total != queued_total || expected_results.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_DEADZONE:   dz_cfg = val[DZ_W-1:0];
      REG_ACCEL_GAIN: gain_cfg = val;
      REG_TIME_RECIP: recip_cfg = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic program_regs(input logic [DZ_W-1:0] dz, input logic [GAIN_W-1:0] gain,
                              input logic [GAIN_W-1:0] recip);
    drain();
    write_reg(REG_DEADZONE, CFG_DATA_W'(dz));
    write_reg(REG_ACCEL_GAIN, gain);
    write_reg(REG_TIME_RECIP, recip);
  endtask

  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_taken) begin
      if (gap_left > 0) begin
        in_ch.valid <= 1'b0;
        gap_left--;
      end else if (sample_queue.size() != 0) begin
        next_sample = sample_queue.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.raw_accel <= next_sample.raw;
        in_ch.sample_ok <= next_sample.ok;
        in_ch.time_us <= next_sample.stamp;
        gap_left = pick_gap();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // long hold-offs let the block fill up and stall its input
  always @(negedge clk) begin
    if (hold_left == 0 && results_seen >= hold_mark) begin
      hold_left = RESULT_HOLD;
      hold_mark += 400;
    end
    if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left--;
    end else if (calm_left > 0) begin
      out_ch.ready <= 1'b1;
      calm_left--;
    end else if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left--;
    end else begin
      out_ch.ready <= 1'b1;
      case ($urandom_range(0, 19))
        0: calm_left = $urandom_range(30, 150);
        1, 2, 3, 4: stall_left = $urandom_range(1, 3);
        5: stall_left = $urandom_range(10, 60);
        default: ;
      endcase
    end
  end

  always @(posedge clk) begin
    in_taken = rst_n && in_ch.valid && in_ch.ready;
    out_taken = rst_n && out_ch.valid && out_ch.ready;
    if (out_taken) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        $error("result with no transaction pending: status %0d", out_ch.status);
        mismatches++;
      end else begin
        want_result = expected_results.pop_front();
        check_field("status", VEL_W'(want_result.status), VEL_W'(out_ch.status));
        check_field("velocity", want_result.velocity, out_ch.velocity);
        check_field("distance", want_result.distance, out_ch.distance);
        check_field("peak_speed", VEL_W'(want_result.peak), VEL_W'(out_ch.peak_speed));
      end
    end
    if (in_taken) begin
      accepted_total++;
      expected_results.push_back(integrate_sample(in_ch.raw_accel, in_ch.sample_ok,
                                                  in_ch.time_us));
    end
    if (in_taken || out_taken || cfg_we) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    int                      i;
    int                      phase;
    int                      phase_start;
    int                      base;
    int                      dz;
    logic signed [RAW_W-1:0] cal_raw;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // zero-offset calibration
    base = int'($urandom_range(0, 4000)) - 2000;
    for (i = 0; i < CAL_SAMPLES; i++) begin
      if (i == 3) cal_raw = 16'sh7FFF;
      else if (i == 7) cal_raw = 16'sh8000;
      else cal_raw = 16'(base + int'($urandom_range(0, 600)) - 300);
      push_sample(cal_raw, (i == 3 || i == 7) || $urandom_range(0, 9) != 0, pick_dt());
    end
    drain();

    dz = int'(dz_cfg);
    push_sample(16'sh7FFF, 1'b0, 10000);
    push_sample(raw_for(0), 1'b1, 10000);
    push_sample(raw_for(5000), 1'b1, 10000);
    push_sample(16'sh8000, 1'b0, 10000);
    push_sample(raw_for(-5000), 1'b1, 10000);
    stamp_now = 32'hFFFF_F000;
    push_sample(raw_for(dz), 1'b1, 0);
    push_sample(raw_for(dz + 1), 1'b1, 32'h2000);
    push_sample(raw_for(-dz - 1), 1'b1, 10000);
    push_sample(16'sh7FFF, 1'b1, 10000);
    push_sample(16'sh8000, 1'b1, 10000);
    push_sample(raw_for(-dz), 1'b1, 10000);
    stamp_now = 32'hFFFF_FFFF;
    push_sample(raw_for(3000), 1'b1, 0);
    push_sample(raw_for(-3000), 1'b1, 1);
    push_sample(raw_for(0), 1'b1, 10000);

    // velocity back to exactly zero while distance stays
    program_regs(DEADZONE_RST, 24'h80_0000, RECIP_RST);
    push_sample(raw_for(4000), 1'b1, 10000);
    push_sample(raw_for(-4000), 1'b1, 10000);
    push_sample(raw_for(0), 1'b1, 10000);
    push_sample(raw_for(4000), 1'b1, 10000);
    push_sample(raw_for(0), 1'b1, 10000);

    // saturation both ways
    program_regs('0, 24'hFF_FFFF, 24'hFF_FFFF);
    push_sample(16'sh7FFF, 1'b1, 32'hFFFF_FFF0);
    push_sample(16'sh7FFF, 1'b1, 32'hFFFF_FFF0);
    push_sample(16'sh8000, 1'b1, 32'hFFFF_FFF0);
    push_sample(16'sh8000, 1'b1, 32'hFFFF_FFF0);
    push_sample(16'sh8000, 1'b1, 32'hFFFF_FFF0);
    push_sample(raw_for(0), 1'b1, 100);

    for (phase = 0; phase < 8; phase++) begin
      case (phase)
        1: program_regs('0, 24'($urandom), 24'($urandom));
        2: program_regs(15'h7FFF, 24'hFF_FFFF, 24'hFF_FFFF);
        3: program_regs(15'($urandom_range(0, 4000)), '0, RECIP_RST);
        4: program_regs(DEADZONE_RST, 24'hFF_FFFF, '0);
        5: program_regs(15'($urandom), 24'($urandom), 24'($urandom));
        6: program_regs(15'($urandom_range(0, 4000)), 24'($urandom_range(0, 2000000)),
                        24'($urandom_range(0, 4000000)));
        default: program_regs(DEADZONE_RST, GAIN_RST, RECIP_RST);
      endcase
      if (phase == 5) write_reg(REG_UNUSED, 24'($urandom));
      phase_start = queued_total;
      while (queued_total - phase_start < PHASE_ITEMS) begin
        if ($urandom_range(0, 99) < 15) begin
          push_sample(16'($urandom), 1'($urandom),
                      $urandom_range(0, 3) == 0 ? $urandom : pick_dt());
        end else begin
          queue_move();
        end
      end
    end

    drain();
    repeat (40) @(negedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/adri_pkg.sv
hdl/adri_in_if.sv
hdl/adri_out_if.sv
hdl/accel_dead_reckon_integrator_core.sv
test/accel_dead_reckon_integrator_core_tb.sv
